@@ rtl/lpri_pkg.sv @@
// Shared types and constants for the linear-probing rehash insert unit.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package lpri_pkg;

  localparam int FUNC_W   = 2;
  localparam int ORDER_W  = 10;
  localparam int HASH_W   = 64;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 3;
  localparam int LG_W     = 4;

  // one table entry: occupied flag, order number, full hash
  localparam int ENTRY_W  = 1 + ORDER_W + HASH_W;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam logic [LG_W-1:0] LG_RESET = 4'd10;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_PLACED     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_SKIPPED    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_READ_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_READ_OCC   = 3'd4;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_RESP
  } state_e;

endpackage

@@ rtl/linear_probe_rehash_insert_unit.sv @@
// Top level of the linear-probing rehash insert unit.
// Depends on lpri_pkg and lpri_ram (one entry RAM holding flag, order and hash).
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command item: insert an
//   old slot, clear the table, or read one slot. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result item per command, in order.
//   cfg_we_i writes table_size_log2 (capacity = 2^value, min 2, clamped to RAM);
//   write it only while the unit is idle.
// Sequencing (one command at a time, one RAM read per cycle):
//   insert: accept, then P probe steps, then the response, P = slots
//     visited (1 when the home slot is free, up to capacity when full).
//   read: accept, RAM read, respond; skipped entry/unused code: accept, respond.
//   clear: RAM sweep of all TABLE_DEPTH entries, then the response.
//   The probe loop is bound by the single RAM read port, one slot per cycle.
// Reset: the unit sweeps all TABLE_DEPTH entries to free and holds in_stall_o
//   high until done. Configuration writes are taken anyway.
// Output stall: the result sits in the output register; the next command can be
//   accepted and worked on, and its result waits until the register drains.

module linear_probe_rehash_insert_unit #(
  parameter int TABLE_DEPTH = lpri_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [lpri_pkg::LG_W-1:0]     cfg_wdata_i,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lpri_pkg::FUNC_W-1:0]   func_i,
  input  logic                          entry_used_i,
  input  logic [lpri_pkg::ORDER_W-1:0]  entry_order_i,
  input  logic [lpri_pkg::HASH_W-1:0]   entry_hash_i,
  input  logic [lpri_pkg::SLOT_W-1:0]   read_slot_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lpri_pkg::SLOT_W-1:0]   slot_index_o,
  output logic [lpri_pkg::ORDER_W-1:0]  out_order_o,
  output logic [lpri_pkg::HASH_W-1:0]   out_hash_o,
  output logic [lpri_pkg::STATUS_W-1:0] status_o
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int LG_MAX = $clog2(TABLE_DEPTH + 1) - 1;

  lpri_pkg::state_e state_q, state_d;

  logic [lpri_pkg::LG_W-1:0]     cfg_q;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [IDX_W:0]                probe_q, probe_d;
  logic [IDX_W-1:0]              sw_q, sw_d;
  logic                          clr_resp_q, clr_resp_d;
  logic [lpri_pkg::ORDER_W-1:0]  ord_q, ord_d;
  logic [lpri_pkg::HASH_W-1:0]   hash_q, hash_d;
  logic [IDX_W-1:0]              res_idx_q, res_idx_d;
  logic [lpri_pkg::ORDER_W-1:0]  res_order_q, res_order_d;
  logic [lpri_pkg::HASH_W-1:0]   res_hash_q, res_hash_d;
  logic [lpri_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic                          out_valid_q, out_valid_d;
  logic [lpri_pkg::SLOT_W-1:0]   out_idx_q, out_idx_d;
  logic [lpri_pkg::ORDER_W-1:0]  out_order_q, out_order_d;
  logic [lpri_pkg::HASH_W-1:0]   out_hash_q, out_hash_d;
  logic [lpri_pkg::STATUS_W-1:0] out_status_q, out_status_d;

  // capacity and probe mask from the configured size
  logic [4:0]       lg_cfg, lg_eff;
  logic [IDX_W:0]   cap;
  logic [IDX_W-1:0] mask;
  logic [31:0]      rslot_ext, res_idx_ext;

  assign lg_cfg = {1'b0, cfg_q};
  always_comb begin
    if (cfg_q == '0) begin
      lg_eff = 5'd1;
    end else if (lg_cfg > 5'(LG_MAX)) begin
      lg_eff = 5'(LG_MAX);
    end else begin
      lg_eff = lg_cfg;
    end
  end
  assign cap         = (IDX_W + 1)'(1) << lg_eff;
  assign mask        = IDX_W'(cap - (IDX_W + 1)'(1));
  assign rslot_ext   = 32'(read_slot_i);
  assign res_idx_ext = 32'(res_idx_q);

  // entry RAM
  logic                         ram_we, ram_re;
  logic [IDX_W-1:0]             ram_waddr, ram_raddr;
  logic [lpri_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic                         rd_occ;
  logic [lpri_pkg::ORDER_W-1:0] rd_order;
  logic [lpri_pkg::HASH_W-1:0]  rd_hash;

  lpri_ram #(
    .WIDTH (lpri_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_occ   = ram_rdata[lpri_pkg::ENTRY_W-1];
  assign rd_order = ram_rdata[lpri_pkg::HASH_W +: lpri_pkg::ORDER_W];
  assign rd_hash  = ram_rdata[lpri_pkg::HASH_W-1:0];

  logic in_acc, out_acc, out_free;
  assign in_acc   = in_valid_i && (state_q == lpri_pkg::ST_IDLE);
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    probe_d      = probe_q;
    sw_d         = sw_q;
    clr_resp_d   = clr_resp_q;
    ord_d        = ord_q;
    hash_d       = hash_q;
    res_idx_d    = res_idx_q;
    res_order_d  = res_order_q;
    res_hash_d   = res_hash_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_acc;
    out_idx_d    = out_idx_q;
    out_order_d  = out_order_q;
    out_hash_d   = out_hash_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = {1'b1, ord_q, hash_q};
    ram_re       = 1'b0;
    ram_raddr    = idx_q;

    unique case (state_q)
      lpri_pkg::ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sw_q;
        ram_wdata = '0;
        sw_d      = sw_q + IDX_W'(1);
        if (sw_q == IDX_W'(TABLE_DEPTH - 1)) begin
          sw_d = '0;
          if (clr_resp_q) begin
            clr_resp_d = 1'b0;
            state_d    = lpri_pkg::ST_RESP;
          end else begin
            state_d = lpri_pkg::ST_IDLE;
          end
        end
      end

      lpri_pkg::ST_IDLE: begin
        if (in_acc) begin
          ord_d        = entry_order_i;
          hash_d       = entry_hash_i;
          probe_d      = '0;
          res_idx_d    = '0;
          res_order_d  = '0;
          res_hash_d   = '0;
          res_status_d = lpri_pkg::STAT_SKIPPED;
          state_d      = lpri_pkg::ST_RESP;
          unique case (func_i)
            lpri_pkg::FUNC_INSERT: begin
              if (entry_used_i) begin
                idx_d     = entry_hash_i[IDX_W-1:0] & mask;
                ram_re    = 1'b1;
                ram_raddr = entry_hash_i[IDX_W-1:0] & mask;
                state_d   = lpri_pkg::ST_CHECK;
              end
            end
            lpri_pkg::FUNC_CLEAR: begin
              res_status_d = lpri_pkg::STAT_READ_OCC;
              clr_resp_d   = 1'b1;
              state_d      = lpri_pkg::ST_SWEEP;
            end
            lpri_pkg::FUNC_READ: begin
              idx_d     = rslot_ext[IDX_W-1:0] & mask;
              ram_re    = 1'b1;
              ram_raddr = rslot_ext[IDX_W-1:0] & mask;
              state_d   = lpri_pkg::ST_READ;
            end
            default: begin
              // unused code answers as skipped
            end
          endcase
        end
      end

      lpri_pkg::ST_CHECK: begin
        if (!rd_occ) begin
          ram_we       = 1'b1;
          res_idx_d    = idx_q;
          res_order_d  = ord_q;
          res_hash_d   = hash_q;
          res_status_d = lpri_pkg::STAT_PLACED;
          state_d      = lpri_pkg::ST_RESP;
        end else if (probe_q + (IDX_W + 1)'(1) == cap) begin
          res_status_d = lpri_pkg::STAT_FULL;
          state_d      = lpri_pkg::ST_RESP;
        end else begin
          // next slot with wrap-around inside the capacity
          idx_d     = (idx_q + IDX_W'(1)) & mask;
          probe_d   = probe_q + (IDX_W + 1)'(1);
          ram_re    = 1'b1;
          ram_raddr = (idx_q + IDX_W'(1)) & mask;
        end
      end

      lpri_pkg::ST_READ: begin
        res_idx_d = idx_q;
        if (rd_occ) begin
          res_order_d  = rd_order;
          res_hash_d   = rd_hash;
          res_status_d = lpri_pkg::STAT_READ_OCC;
        end else begin
          res_order_d  = '0;
          res_hash_d   = '0;
          res_status_d = lpri_pkg::STAT_READ_EMPTY;
        end
        state_d = lpri_pkg::ST_RESP;
      end

      lpri_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_idx_d    = res_idx_ext[lpri_pkg::SLOT_W-1:0];
          out_order_d  = res_order_q;
          out_hash_d   = res_hash_q;
          out_status_d = res_status_q;
          state_d      = lpri_pkg::ST_IDLE;
        end
      end

      default: state_d = lpri_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpri_pkg::ST_SWEEP;
      cfg_q       <= lpri_pkg::LG_RESET;
      sw_q        <= '0;
      clr_resp_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sw_q        <= sw_d;
      clr_resp_q  <= clr_resp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    probe_q      <= probe_d;
    ord_q        <= ord_d;
    hash_q       <= hash_d;
    res_idx_q    <= res_idx_d;
    res_order_q  <= res_order_d;
    res_hash_q   <= res_hash_d;
    res_status_q <= res_status_d;
    out_idx_q    <= out_idx_d;
    out_order_q  <= out_order_d;
    out_hash_q   <= out_hash_d;
    out_status_q <= out_status_d;
  end

  assign in_stall_o   = (state_q != lpri_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign slot_index_o = out_idx_q;
  assign out_order_o  = out_order_q;
  assign out_hash_o   = out_hash_q;
  assign status_o     = out_status_q;

  // the probe loop never runs past the capacity
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpri_pkg::ST_CHECK) |-> (probe_q < cap))
    else $error("probe count reached capacity inside the probe loop");

  // RAM is written only by the sweep or by a placement
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == lpri_pkg::ST_SWEEP || state_q == lpri_pkg::ST_CHECK))
    else $error("entry RAM written outside sweep or probe");

  // a placed slot lies inside the capacity
  a_placed_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpri_pkg::ST_RESP && res_status_q == lpri_pkg::STAT_PLACED)
      |-> ((res_idx_q & ~mask) == '0))
    else $error("placed slot outside the configured capacity");

  // a waiting result is not overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && state_q == lpri_pkg::ST_RESP)
      |=> (state_q == lpri_pkg::ST_RESP && $stable(out_status_q)))
    else $error("response left while output register was full");

endmodule

@@ rtl/lpri_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
